>>> hw/rtl/clock_frame_replacer_top_defines.svh
// Assertion macros for the clock frame replacer.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef CLOCK_FRAME_REPLACER_TOP_DEFINES_SVH
`define CLOCK_FRAME_REPLACER_TOP_DEFINES_SVH

// Holds at every clock edge out of reset.
`define CFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When ante holds, cons holds at the next clock edge.
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cfr_pkg.sv
// Shared types and constants for the clock frame replacer.
// No dependencies; used by cfr_cell and clock_frame_replacer_top.
`default_nettype none

package cfr_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int FRAME_W    = 6;
  localparam int CNT_W      = 7;
  localparam int SCAN_W     = CNT_W + 1;

  localparam logic [CNT_W-1:0] FRAMES_RESET = CNT_W'(MAX_FRAMES);

  localparam logic [1:0] ACT_ACCESS = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_VICTIM = 2'd2;
  localparam logic [1:0] ACT_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [FRAME_W-1:0] frame;
    logic               make_evictable;
  } cfr_in_t;

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] victim_frame;
    logic [CNT_W-1:0]   evictable_count;
  } cfr_out_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    logic acc;
    logic set;
    logic rem;
    logic mark;
    logic step;
    logic tok_load;
  } cfr_cmd_t;

  // Per-cell status back to the controller.
  typedef struct packed {
    logic pres;
    logic evict;
    logic refd;
    logic tok;
  } cfr_cell_st_t;

endpackage

`default_nettype wire

>>> hw/rtl/cfr_cell.sv
// One frame slot of the clock chain: present/evictable/referenced bits plus the hand token.
// Depends on cfr_pkg.
`default_nettype none

module cfr_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfr_pkg::cfr_cmd_t cmd,
  input  wire logic             sel,
  input  wire logic             tok_in,
  input  wire logic             tok_seed,
  output cfr_pkg::cfr_cell_st_t st
);
  import cfr_pkg::*;

  logic pres_r, evict_r, refd_r, tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r  <= 1'b0;
      evict_r <= 1'b0;
      refd_r  <= 1'b0;
      tok_r   <= tok_seed;
    end else begin
      if (cmd.tok_load) begin
        tok_r <= tok_seed;
      end else if (cmd.step) begin
        tok_r <= tok_in;
      end

      if (sel && cmd.acc) begin
        pres_r <= 1'b1;
        refd_r <= 1'b1;
      end else if (sel && cmd.set) begin
        if (!pres_r) begin
          pres_r <= 1'b1;
          refd_r <= 1'b1;
        end
        evict_r <= cmd.mark;
      end else if (sel && cmd.rem) begin
        pres_r  <= 1'b0;
        evict_r <= 1'b0;
        refd_r  <= 1'b0;
      end else if (cmd.step && tok_r && pres_r && evict_r) begin
        // second chance, or eviction when already unreferenced
        if (refd_r) begin
          refd_r <= 1'b0;
        end else begin
          pres_r  <= 1'b0;
          evict_r <= 1'b0;
        end
      end
    end
  end

  assign st.pres  = pres_r;
  assign st.evict = evict_r;
  assign st.refd  = refd_r;
  assign st.tok   = tok_r;

endmodule

`default_nettype wire

>>> hw/rtl/clock_frame_replacer_top.sv
// Clock frame replacer top: controller, capacity register and the chain of frame cells.
// Depends on cfr_pkg, cfr_cell and clock_frame_replacer_top_defines.svh.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | cfr_in_t
//   out_    | output    | out_valid / out_stall | cfr_out_t
//   cfg_    | input     | cfg_we                | cfg_wdata (frames_in_use)
//
// Access, set evictable, remove and an empty victim pick: result registered when the request is accepted.
// Victim pick: the request is accepted, then a sweep runs until the first hit or two full turns;
// the hand token walks one cell per cycle along the chain.
// Synchronous reset clears all frame bits at once, hand to frame 0, capacity to 64.
// Input stalls while a sweep runs or while the output register is full and stalled.
`default_nettype none

module clock_frame_replacer_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire cfr_pkg::cfr_in_t      in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output cfr_pkg::cfr_out_t          out_data,
  input  wire logic                  cfg_we,
  input  wire logic [cfr_pkg::CNT_W-1:0] cfg_wdata
);
  import cfr_pkg::*;

`include "clock_frame_replacer_top_defines.svh"

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SWEEP = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [FRAME_W-1:0]  hand_r, hand_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [SCAN_W-1:0]   scan_r, scan_nxt;
  logic [CNT_W-1:0]    frames_r;
  logic                out_valid_r;
  cfr_out_t            out_data_r;

  cfr_cmd_t            cmd;
  cfr_cell_st_t        cell_st [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] pres_v, evict_v, refd_v, tok_v;

  logic [CNT_W-1:0]    cap;
  logic [SCAN_W-1:0]   limit;
  logic [FRAME_W-1:0]  wrap_idx;
  logic [FRAME_W-1:0]  hand_adv;
  logic                in_take, out_take, frame_ok, hit, out_load;
  cfr_out_t            res;

  assign cap      = (frames_r < FRAMES_RESET) ? frames_r : FRAMES_RESET;
  assign limit    = {cap, 1'b0};
  assign wrap_idx = FRAME_W'(cap - CNT_W'(1));
  assign hand_adv = ((CNT_W'(hand_r) + CNT_W'(1)) >= cap) ? '0 : FRAME_W'(hand_r + 1'b1);

  assign in_stall = !((state_r == ST_IDLE) && (!out_valid_r || !out_stall));
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign frame_ok = CNT_W'(in_data.frame) < cap;
  assign hit      = pres_v[hand_r] && evict_v[hand_r] && !refd_v[hand_r];

  // cell chain; token passes to the next cell below capacity, wraps to cell 0
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = tok_v[wrap_idx];
    end else begin : g_body
      assign tok_in = tok_v[i-1] && (CNT_W'(i) < cap);
    end

    cfr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (in_data.frame == FRAME_W'(i)),
      .tok_in   (tok_in),
      .tok_seed (i == 0),
      .st       (cell_st[i])
    );

    assign pres_v[i]  = cell_st[i].pres;
    assign evict_v[i] = cell_st[i].evict;
    assign refd_v[i]  = cell_st[i].refd;
    assign tok_v[i]   = cell_st[i].tok;
  end

  always_comb begin
    cmd       = '0;
    cmd.mark  = in_data.make_evictable;
    state_nxt = state_r;
    hand_nxt  = hand_r;
    total_nxt = total_r;
    scan_nxt  = scan_r;
    out_load  = 1'b0;
    res.found        = 1'b0;
    res.victim_frame = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          case (in_data.action)
            ACT_ACCESS: begin
              cmd.acc  = frame_ok;
              out_load = 1'b1;
            end
            ACT_SET: begin
              cmd.set  = frame_ok;
              out_load = 1'b1;
              if (frame_ok && (evict_v[in_data.frame] != in_data.make_evictable)) begin
                if (in_data.make_evictable) begin
                  total_nxt = total_r + 1'b1;
                end else if (total_r != '0) begin
                  total_nxt = total_r - 1'b1;
                end
              end
            end
            ACT_REMOVE: begin
              cmd.rem  = frame_ok;
              out_load = 1'b1;
              if (frame_ok && pres_v[in_data.frame] && evict_v[in_data.frame] &&
                  (total_r != '0)) begin
                total_nxt = total_r - 1'b1;
              end
            end
            ACT_VICTIM: begin
              if ((total_r != '0) && (cap != '0)) begin
                state_nxt = ST_SWEEP;
                scan_nxt  = '0;
                if (CNT_W'(hand_r) >= cap) begin
                  hand_nxt     = '0;
                  cmd.tok_load = 1'b1;
                end
              end else begin
                out_load = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        cmd.step = 1'b1;
        hand_nxt = hand_adv;
        scan_nxt = scan_r + 1'b1;
        if (hit) begin
          res.found        = 1'b1;
          res.victim_frame = hand_r;
          if (total_r != '0) begin
            total_nxt = total_r - 1'b1;
          end
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else if ((scan_r + 1'b1) == limit) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.evictable_count = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hand_r      <= '0;
      total_r     <= '0;
      scan_r      <= '0;
      frames_r    <= FRAMES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hand_r   <= hand_nxt;
      total_r  <= total_nxt;
      scan_r   <= scan_nxt;
      if (cfg_we) begin
        frames_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CFR_ASSERT_ALWAYS(a_tok_onehot, $onehot(tok_v), "hand token not one-hot")
  `CFR_ASSERT_ALWAYS(a_tok_at_hand, tok_v[hand_r], "hand token out of step with hand")
  `CFR_ASSERT_ALWAYS(a_total_max, total_r <= CNT_W'(MAX_FRAMES), "evictable count overflow")
  `CFR_ASSERT_ALWAYS(a_scan_bound, (state_r != ST_SWEEP) || (scan_r < limit), "sweep overrun")
  `CFR_ASSERT_NEXT(a_sweep_result, (state_r == ST_SWEEP) && (state_nxt == ST_IDLE), out_valid_r, "sweep ended without result")

endmodule

`default_nettype wire

>>> tb/clock_frame_replacer_top_tb.sv
// Self-checking testbench for clock_frame_replacer_top: directed and random transactions,
// a scoreboard with its own clock-replacer predictor, random idling on both channels.
// Depends on cfr_pkg and the clock_frame_replacer_top RTL.
`default_nettype none

module clock_frame_replacer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfr_pkg::*;

  localparam int DRAIN_CYCLES = 2 * MAX_FRAMES + 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 2500;
  localparam int PHASE_ITEMS  = 220;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  cfr_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  cfr_out_t             out_data;
  logic                 cfg_we;
  logic [CNT_W-1:0]     cfg_wdata;

  clock_frame_replacer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  class replacer_scoreboard;
    bit [MAX_FRAMES-1:0] present;
    bit [MAX_FRAMES-1:0] evictable;
    bit [MAX_FRAMES-1:0] referenced;
    int unsigned         hand;
    int unsigned         evict_total;
    bit [CNT_W-1:0]      frames_cfg;
    cfr_out_t            pending_results[$];
    int                  errors;

    function new();
      present     = '0;
      evictable   = '0;
      referenced  = '0;
      hand        = 0;
      evict_total = 0;
      frames_cfg  = FRAMES_RESET;
      errors      = 0;
    endfunction

    function void set_frames(bit [CNT_W-1:0] v);
      frames_cfg = v;
    endfunction

    function int unsigned capacity();
      return (frames_cfg < MAX_FRAMES) ? frames_cfg : MAX_FRAMES;
    endfunction

    function void advance_hand(int unsigned cap);
      hand = (hand + 1 >= cap) ? 0 : hand + 1;
    endfunction

    // Predicts the result of one accepted request and queues it.
    function void apply_request(cfr_in_t t);
      int unsigned cap;
      int unsigned f;
      int unsigned h;
      cfr_out_t    r;
      cap = capacity();
      f   = t.frame;
      r   = '0;
      case (t.action)
        ACT_ACCESS: begin
          if (f < cap) begin
            present[f]    = 1'b1;
            referenced[f] = 1'b1;
          end
        end
        ACT_SET: begin
          if (f < cap) begin
            if (!present[f]) begin
              present[f]    = 1'b1;
              referenced[f] = 1'b1;
            end
            if (evictable[f] != t.make_evictable) begin
              evictable[f] = t.make_evictable;
              if (t.make_evictable) evict_total++;
              else if (evict_total > 0) evict_total--;
            end
          end
        end
        ACT_VICTIM: begin
          if (evict_total != 0 && cap != 0) begin
            if (hand >= cap) hand = 0;
            for (int n = 0; n < 2 * cap; n++) begin
              h = hand;
              if (present[h] && evictable[h]) begin
                if (referenced[h]) begin
                  referenced[h] = 1'b0;
                end else begin
                  present[h]     = 1'b0;
                  evictable[h]   = 1'b0;
                  r.found        = 1'b1;
                  r.victim_frame = FRAME_W'(h);
                  advance_hand(cap);
                  if (evict_total > 0) evict_total--;
                  break;
                end
              end
              advance_hand(cap);
            end
          end
        end
        default: begin
          if (f < cap) begin
            if (present[f] && evictable[f] && evict_total > 0) evict_total--;
            present[f]    = 1'b0;
            evictable[f]  = 1'b0;
            referenced[f] = 1'b0;
          end
        end
      endcase
      r.evictable_count = CNT_W'(evict_total);
      pending_results.push_back(r);
    endfunction

    function void check_result(cfr_out_t got);
      cfr_out_t exp;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %p", got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.found !== exp.found) begin
        $error("found mismatch: expected %0d, actual %0d", exp.found, got.found);
        errors++;
      end
      if (got.victim_frame !== exp.victim_frame) begin
        $error("victim_frame mismatch: expected %0d, actual %0d",
               exp.victim_frame, got.victim_frame);
        errors++;
      end
      if (got.evictable_count !== exp.evictable_count) begin
        $error("evictable_count mismatch: expected %0d, actual %0d",
               exp.evictable_count, got.evictable_count);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  replacer_scoreboard sb;
  bit quiet;
  bit hold_req;
  int idle_cycles;

  always #5 clk = ~clk;

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic cfr_in_t mk_item(logic [1:0] act, int unsigned f, bit mark);
    cfr_in_t t;
    t.action         = act;
    t.frame          = FRAME_W'(f);
    t.make_evictable = mark;
    return t;
  endfunction

  // Mostly frames inside the capacity, with a share drawn from the whole frame range.
  function automatic cfr_in_t random_item(int unsigned cap);
    int r;
    cfr_in_t t;
    r = $urandom_range(0, 99);
    if (r < 28) t.action = ACT_ACCESS;
    else if (r < 58) t.action = ACT_SET;
    else if (r < 83) t.action = ACT_VICTIM;
    else t.action = ACT_REMOVE;
    if (cap != 0 && $urandom_range(0, 9) != 0) t.frame = FRAME_W'($urandom_range(0, cap - 1));
    else t.frame = FRAME_W'($urandom_range(0, MAX_FRAMES - 1));
    if (t.action == ACT_SET) t.make_evictable = ($urandom_range(0, 3) != 0);
    else t.make_evictable = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic send_item(cfr_in_t t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    sb.apply_request(t);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // a sweep can still be running only if a result is missing; allow it to land
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frames(int unsigned v);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_frames(CNT_W'(v));
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[clock_frame_replacer_top] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned phase_frames[8];
    idle_cycles = 0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    sb          = new();
    phase_frames = '{127, 2, 1, 0, 33, 64, 17, 64};
    phase_frames[6] = $urandom_range(0, 127);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pick, second chance, no-op set, remove of absent frame.
    send_item(mk_item(ACT_VICTIM, 0, 1'b0));
    send_item(mk_item(ACT_ACCESS, 0, 1'b0));
    send_item(mk_item(ACT_ACCESS, 63, 1'b1));
    send_item(mk_item(ACT_SET, 0, 1'b1));
    send_item(mk_item(ACT_SET, 63, 1'b1));
    send_item(mk_item(ACT_SET, 5, 1'b1));
    send_item(mk_item(ACT_SET, 5, 1'b1));
    send_item(mk_item(ACT_VICTIM, 63, 1'b1));
    send_item(mk_item(ACT_VICTIM, 0, 1'b0));
    send_item(mk_item(ACT_SET, 63, 1'b0));
    send_item(mk_item(ACT_REMOVE, 5, 1'b1));
    send_item(mk_item(ACT_REMOVE, 0, 1'b0));
    send_item(mk_item(ACT_VICTIM, 0, 1'b0));
    send_item(mk_item(ACT_SET, 40, 1'b1));
    send_item(mk_item(ACT_ACCESS, 10, 1'b0));
    send_item(mk_item(ACT_SET, 10, 1'b1));
    // Shrink: frame 40 stays counted but can never be picked, so the sweep runs dry.
    wait_idle();
    write_frames(20);
    send_item(mk_item(ACT_REMOVE, 10, 1'b0));
    send_item(mk_item(ACT_VICTIM, 0, 1'b0));
    send_item(mk_item(ACT_ACCESS, 30, 1'b1));
    send_item(mk_item(ACT_SET, 50, 1'b1));
    send_item(mk_item(ACT_REMOVE, 40, 1'b0));
    // Hand left above the new capacity restarts at frame 0.
    wait_idle();
    write_frames(3);
    send_item(mk_item(ACT_SET, 1, 1'b1));
    send_item(mk_item(ACT_VICTIM, 0, 1'b0));
    wait_idle();
    write_frames(0);
    send_item(mk_item(ACT_VICTIM, 0, 1'b0));
    send_item(mk_item(ACT_ACCESS, 0, 1'b1));
    wait_idle();
    write_frames(127);
    send_item(mk_item(ACT_SET, 40, 1'b0));

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_frames(phase_frames[p]);
      quiet = (p == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 40) hold_req = 1'b1;
        send_item(random_item(sb.capacity()));
      end
    end
    quiet = 1'b0;
    wait_idle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[clock_frame_replacer_top] OK");
    end else begin
      $display("[clock_frame_replacer_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
